@@ rtl/sbe_pkg.sv @@
`default_nettype none
package sbe_pkg;

  localparam logic [7:0] OP_TRAP  = 8'h00;
  localparam logic [7:0] OP_RET   = 8'h01;
  localparam logic [7:0] OP_BRK   = 8'h02;
  localparam logic [7:0] OP_PRINT = 8'h03;
  localparam logic [7:0] OP_NOP   = 8'h10;
  localparam logic [7:0] OP_ADD   = 8'h11;
  localparam logic [7:0] OP_SUB   = 8'h12;
  localparam logic [7:0] OP_MUL   = 8'h13;
  localparam logic [7:0] OP_DIV   = 8'h14;
  localparam logic [7:0] OP_MOD   = 8'h15;
  localparam logic [7:0] OP_SHL   = 8'h16;
  localparam logic [7:0] OP_SHRL  = 8'h17;
  localparam logic [7:0] OP_SHRA  = 8'h18;
  localparam logic [7:0] OP_IMM   = 8'h40;
  localparam logic [7:0] OP_CONST = 8'h41;
  localparam logic [7:0] OP_BIAS  = 8'h42;
  localparam logic [7:0] OP_DUP   = 8'h60;
  localparam logic [7:0] OP_ROT2  = 8'h61;
  localparam logic [7:0] OP_ROT3  = 8'h62;

  typedef enum logic [3:0] {
    ST_OK     = 4'd0,
    ST_PRINT  = 4'd1,
    ST_RET    = 4'd2,
    ST_TRAP   = 4'd3,
    ST_BADOP  = 4'd4,
    ST_UNDER  = 4'd5,
    ST_OVER   = 4'd6,
    ST_BADIDX = 4'd7,
    ST_DIV0   = 4'd8,
    ST_HALTED = 4'd9
  } status_t;

  typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_op_t;
  typedef enum logic [1:0] {CAP_NONE, CAP_R0, CAP_R1, CAP_R2} cap_t;
  typedef enum logic [1:0] {LV_HOLD, LV_INC, LV_DEC} lvl_t;
  typedef enum logic [2:0] {WS_R0, WS_R1, WS_R2, WS_ALU, WS_MD, WS_IMM, WS_POOL} wr_src_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RD0, S_RD1, S_RD2, S_RD3, S_EXEC, S_MD, S_W1, S_W2, S_CPUSH, S_DONE
  } state_t;

  typedef struct packed {
    logic               op;
    logic [7:0]         opcode;
    logic signed [7:0]  param;
    logic [7:0]         pool_index;
    logic signed [63:0] pool_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [63:0] value;
    logic [15:0]        instr_count;
  } out_word_t;

  typedef struct packed {
    logic    take;
    logic    stk_rd;
    logic [1:0] rd_off;
    cap_t    cap;
    logic    stk_wr;
    logic [1:0] wr_off;
    wr_src_t wr_src;
    lvl_t    lvl;
    logic    pool_rd;
    logic    pool_wr;
    logic    wb_add;
    logic    md_start;
    md_op_t  md_op;
    logic    fin;
    status_t fin_status;
    logic    fin_val;
    logic    counted;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic       op;
    logic [7:0] opcode;
    logic       halted;
    logic       ge1;
    logic       ge2;
    logic       ge3;
    logic       full;
    logic       idx_ok;
    logic       div_zero;
    logic       md_done;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/sbe_muldiv.sv @@
`default_nettype none
module sbe_muldiv (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire sbe_pkg::md_op_t op,
  input  wire logic [63:0]    a,
  input  wire logic [63:0]    b,
  output logic                done,
  output logic [63:0]         result
);

  logic            busy;
  logic [5:0]      cnt;
  sbe_pkg::md_op_t mode;
  logic [63:0]     x, y, acc, rem;
  logic            neg_q, neg_r;
  logic [63:0]     rem_sh;
  logic [64:0]     trial;

  assign rem_sh = {rem[62:0], x[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode  <= op;
      acc   <= '0;
      rem   <= '0;
      neg_q <= a[63] ^ b[63];
      neg_r <= a[63];
      if (op == sbe_pkg::MD_MUL) begin
        x <= a;
        y <= b;
      end else begin
        x <= a[63] ? 64'd0 - a : a;
        y <= b[63] ? 64'd0 - b : b;
      end
    end else if (busy) begin
      if (mode == sbe_pkg::MD_MUL) begin
        if (y[0]) acc <= acc + x;
        x <= {x[62:0], 1'b0};
        y <= {1'b0, y[63:1]};
      end else if (trial[64]) begin
        rem <= rem_sh;
        x   <= {x[62:0], 1'b0};
      end else begin
        rem <= trial[63:0];
        x   <= {x[62:0], 1'b1};
      end
    end
  end

  always_comb begin
    case (mode)
      sbe_pkg::MD_MUL: result = acc;
      sbe_pkg::MD_DIV: result = neg_q ? 64'd0 - x : x;
      default:         result = neg_r ? 64'd0 - rem : rem;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/sbe_dpath.sv @@
`default_nettype none
module sbe_dpath #(
  parameter int STACK_DEPTH = 64,
  parameter int POOL_DEPTH  = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sbe_pkg::cmd_t     cmd,
  input  wire sbe_pkg::in_word_t item,
  input  wire logic              res_ready,
  output sbe_pkg::sts_t          sts,
  output sbe_pkg::out_word_t     res,
  output logic                   res_valid
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam logic [16:0] POOL_LIM = 17'(POOL_DEPTH);
  localparam logic [LW-1:0] STK_LIM = LW'(STACK_DEPTH);

  logic [63:0] stk  [STACK_DEPTH];
  logic [63:0] pool [POOL_DEPTH];

  sbe_pkg::in_word_t inr;
  logic [LW-1:0] level;
  logic [15:0]   wbase;
  logic [15:0]   count;
  logic          halted;
  logic [63:0]   rd_q, pool_q, r0, r1, r2;
  logic [3:0]    res_status;
  logic [63:0]   res_value;
  logic [15:0]   res_count;

  logic [LW-1:0] rd_lvl, wr_lvl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wdata, alu, md_res, imm;
  logic [16:0]   cidx, lidx;
  logic [5:0]    sh;
  logic          md_done;

  assign imm     = {{56{inr.param[7]}}, inr.param};
  assign cidx    = {wbase[15], wbase} + {{9{inr.param[7]}}, inr.param};
  assign lidx    = {9'd0, inr.pool_index};
  assign rd_lvl  = level - LW'(cmd.rd_off);
  assign wr_lvl  = level - LW'(cmd.wr_off);
  assign rd_addr = rd_lvl[AW-1:0];
  assign wr_addr = wr_lvl[AW-1:0];
  assign sh      = r0[5:0];

  always_comb begin
    case (inr.opcode)
      sbe_pkg::OP_ADD:  alu = r1 + r0;
      sbe_pkg::OP_SUB:  alu = r1 - r0;
      sbe_pkg::OP_SHL:  alu = r1 << sh;
      sbe_pkg::OP_SHRL: alu = r1 >> sh;
      default:          alu = 64'($signed(r1) >>> sh);
    endcase
  end

  always_comb begin
    case (cmd.wr_src)
      sbe_pkg::WS_R0:  wdata = r0;
      sbe_pkg::WS_R1:  wdata = r1;
      sbe_pkg::WS_R2:  wdata = r2;
      sbe_pkg::WS_ALU: wdata = alu;
      sbe_pkg::WS_MD:  wdata = md_res;
      sbe_pkg::WS_IMM: wdata = imm;
      default:         wdata = pool_q;
    endcase
  end

  sbe_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.md_start),
    .op     (cmd.md_op),
    .a      (r1),
    .b      (r0),
    .done   (md_done),
    .result (md_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.stk_wr) stk[wr_addr] <= wdata;
    if (cmd.stk_rd) rd_q <= stk[rd_addr];
    if (cmd.pool_wr && (lidx < POOL_LIM)) pool[lidx[PW-1:0]] <= inr.pool_value;
    if (cmd.pool_rd) pool_q <= pool[cidx[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) inr <= item;
    case (cmd.cap)
      sbe_pkg::CAP_R0: r0 <= rd_q;
      sbe_pkg::CAP_R1: r1 <= rd_q;
      sbe_pkg::CAP_R2: r2 <= rd_q;
      default: ;
    endcase
    if (cmd.fin) begin
      res_status <= cmd.fin_status;
      res_value  <= cmd.fin_val ? r0 : 64'd0;
      res_count  <= count;
    end
    if (cmd.out_load) res <= '{status: res_status, value: res_value, instr_count: res_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      wbase     <= '0;
      count     <= '0;
      halted    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (cmd.lvl)
        sbe_pkg::LV_INC: level <= level + LW'(1);
        sbe_pkg::LV_DEC: level <= level - LW'(1);
        default: ;
      endcase
      if (cmd.wb_add) wbase <= wbase + {{8{inr.param[7]}}, inr.param};
      if (cmd.fin && cmd.counted) begin
        count <= count + 16'd1;
        if (cmd.fin_status != sbe_pkg::ST_OK && cmd.fin_status != sbe_pkg::ST_PRINT)
          halted <= 1'b1;
      end
      if (cmd.out_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  assign sts.op       = inr.op;
  assign sts.opcode   = inr.opcode;
  assign sts.halted   = halted;
  assign sts.ge1      = level >= LW'(1);
  assign sts.ge2      = level >= LW'(2);
  assign sts.ge3      = level >= LW'(3);
  assign sts.full     = level >= STK_LIM;
  assign sts.idx_ok   = !cidx[16] && (cidx < POOL_LIM);
  assign sts.div_zero = r0 == 64'd0;
  assign sts.md_done  = md_done;
  assign sts.out_free = !res_valid || res_ready;

endmodule
`default_nettype wire

@@ rtl/sbe_ctrl.sv @@
`default_nettype none
module sbe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire sbe_pkg::sts_t sts,
  output logic               item_ready,
  output sbe_pkg::cmd_t      cmd
);

  sbe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= sbe_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      sbe_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = sbe_pkg::S_DEC;
        end
      end
      sbe_pkg::S_DEC: begin
        state_next = sbe_pkg::S_DONE;
        cmd.fin    = 1'b1;
        cmd.fin_status = sbe_pkg::ST_OK;
        if (sts.op) begin
          cmd.pool_wr = 1'b1;
        end else if (sts.halted) begin
          cmd.fin_status = sbe_pkg::ST_HALTED;
        end else begin
          cmd.counted = 1'b1;
          unique case (sts.opcode) inside
            sbe_pkg::OP_TRAP: cmd.fin_status = sbe_pkg::ST_TRAP;
            sbe_pkg::OP_NOP: ;
            sbe_pkg::OP_BIAS: cmd.wb_add = 1'b1;
            sbe_pkg::OP_RET, sbe_pkg::OP_PRINT, sbe_pkg::OP_DUP: begin
              if (!sts.ge1) cmd.fin_status = sbe_pkg::ST_UNDER;
              else if (sts.opcode == sbe_pkg::OP_DUP && sts.full)
                cmd.fin_status = sbe_pkg::ST_OVER;
              else begin
                cmd.fin    = 1'b0;
                state_next = sbe_pkg::S_RD0;
              end
            end
            sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
            sbe_pkg::OP_MOD, sbe_pkg::OP_SHL, sbe_pkg::OP_SHRL, sbe_pkg::OP_SHRA,
            sbe_pkg::OP_ROT2: begin
              if (!sts.ge2) cmd.fin_status = sbe_pkg::ST_UNDER;
              else begin
                cmd.fin    = 1'b0;
                state_next = sbe_pkg::S_RD0;
              end
            end
            sbe_pkg::OP_ROT3: begin
              if (!sts.ge3) cmd.fin_status = sbe_pkg::ST_UNDER;
              else begin
                cmd.fin    = 1'b0;
                state_next = sbe_pkg::S_RD0;
              end
            end
            sbe_pkg::OP_IMM: begin
              if (sts.full) cmd.fin_status = sbe_pkg::ST_OVER;
              else begin
                cmd.stk_wr = 1'b1;
                cmd.wr_off = 2'd0;
                cmd.wr_src = sbe_pkg::WS_IMM;
                cmd.lvl    = sbe_pkg::LV_INC;
              end
            end
            sbe_pkg::OP_CONST: begin
              if (!sts.idx_ok) cmd.fin_status = sbe_pkg::ST_BADIDX;
              else if (sts.full) cmd.fin_status = sbe_pkg::ST_OVER;
              else begin
                cmd.fin     = 1'b0;
                cmd.pool_rd = 1'b1;
                state_next  = sbe_pkg::S_CPUSH;
              end
            end
            default: cmd.fin_status = sbe_pkg::ST_BADOP;
          endcase
        end
      end
      sbe_pkg::S_RD0: begin
        cmd.stk_rd = 1'b1;
        cmd.rd_off = 2'd1;
        state_next = sbe_pkg::S_RD1;
      end
      sbe_pkg::S_RD1: begin
        cmd.cap    = sbe_pkg::CAP_R0;
        cmd.stk_rd = 1'b1;
        cmd.rd_off = 2'd2;
        state_next = sbe_pkg::S_RD2;
      end
      sbe_pkg::S_RD2: begin
        cmd.cap    = sbe_pkg::CAP_R1;
        cmd.stk_rd = 1'b1;
        cmd.rd_off = 2'd3;
        state_next = sbe_pkg::S_RD3;
      end
      sbe_pkg::S_RD3: begin
        cmd.cap    = sbe_pkg::CAP_R2;
        state_next = sbe_pkg::S_EXEC;
      end
      sbe_pkg::S_EXEC: begin
        cmd.counted    = 1'b1;
        cmd.fin        = 1'b1;
        cmd.fin_status = sbe_pkg::ST_OK;
        state_next     = sbe_pkg::S_DONE;
        unique case (sts.opcode) inside
          sbe_pkg::OP_RET: begin
            cmd.fin_status = sbe_pkg::ST_RET;
            cmd.fin_val    = 1'b1;
          end
          sbe_pkg::OP_PRINT: begin
            cmd.fin_status = sbe_pkg::ST_PRINT;
            cmd.fin_val    = 1'b1;
            cmd.lvl        = sbe_pkg::LV_DEC;
          end
          sbe_pkg::OP_DUP: begin
            cmd.stk_wr = 1'b1;
            cmd.wr_off = 2'd0;
            cmd.wr_src = sbe_pkg::WS_R0;
            cmd.lvl    = sbe_pkg::LV_INC;
          end
          sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_SHL, sbe_pkg::OP_SHRL,
          sbe_pkg::OP_SHRA: begin
            cmd.stk_wr = 1'b1;
            cmd.wr_off = 2'd2;
            cmd.wr_src = sbe_pkg::WS_ALU;
            cmd.lvl    = sbe_pkg::LV_DEC;
          end
          sbe_pkg::OP_MUL, sbe_pkg::OP_DIV, sbe_pkg::OP_MOD: begin
            if (sts.opcode != sbe_pkg::OP_MUL && sts.div_zero) begin
              cmd.fin_status = sbe_pkg::ST_DIV0;
            end else begin
              cmd.fin      = 1'b0;
              cmd.md_start = 1'b1;
              cmd.md_op    = (sts.opcode == sbe_pkg::OP_MUL) ? sbe_pkg::MD_MUL :
                             (sts.opcode == sbe_pkg::OP_DIV) ? sbe_pkg::MD_DIV :
                                                               sbe_pkg::MD_MOD;
              state_next   = sbe_pkg::S_MD;
            end
          end
          sbe_pkg::OP_ROT2, sbe_pkg::OP_ROT3: begin
            cmd.fin    = 1'b0;
            cmd.stk_wr = 1'b1;
            cmd.wr_off = (sts.opcode == sbe_pkg::OP_ROT2) ? 2'd1 : 2'd3;
            cmd.wr_src = sbe_pkg::WS_R1;
            state_next = sbe_pkg::S_W1;
          end
          default: cmd.fin_status = sbe_pkg::ST_BADOP;
        endcase
      end
      sbe_pkg::S_W1: begin
        cmd.stk_wr = 1'b1;
        cmd.wr_off = 2'd2;
        cmd.wr_src = sbe_pkg::WS_R0;
        if (sts.opcode == sbe_pkg::OP_ROT2) begin
          cmd.fin        = 1'b1;
          cmd.counted    = 1'b1;
          cmd.fin_status = sbe_pkg::ST_OK;
          state_next     = sbe_pkg::S_DONE;
        end else begin
          state_next = sbe_pkg::S_W2;
        end
      end
      sbe_pkg::S_W2: begin
        cmd.stk_wr     = 1'b1;
        cmd.wr_off     = 2'd1;
        cmd.wr_src     = sbe_pkg::WS_R2;
        cmd.fin        = 1'b1;
        cmd.counted    = 1'b1;
        cmd.fin_status = sbe_pkg::ST_OK;
        state_next     = sbe_pkg::S_DONE;
      end
      sbe_pkg::S_MD: begin
        if (sts.md_done) begin
          cmd.stk_wr     = 1'b1;
          cmd.wr_off     = 2'd2;
          cmd.wr_src     = sbe_pkg::WS_MD;
          cmd.lvl        = sbe_pkg::LV_DEC;
          cmd.fin        = 1'b1;
          cmd.counted    = 1'b1;
          cmd.fin_status = sbe_pkg::ST_OK;
          state_next     = sbe_pkg::S_DONE;
        end
      end
      sbe_pkg::S_CPUSH: begin
        cmd.stk_wr     = 1'b1;
        cmd.wr_off     = 2'd0;
        cmd.wr_src     = sbe_pkg::WS_POOL;
        cmd.lvl        = sbe_pkg::LV_INC;
        cmd.fin        = 1'b1;
        cmd.counted    = 1'b1;
        cmd.fin_status = sbe_pkg::ST_OK;
        state_next     = sbe_pkg::S_DONE;
      end
      sbe_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = sbe_pkg::S_IDLE;
        end
      end
      default: state_next = sbe_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/stack_bytecode_executor.sv @@
// Stack bytecode executor: one instruction or constant pool load per input word.
// Input channel item_valid/item_ready carries item (op, opcode, param,
// pool_index, pool_value); output channel res_valid/res_ready carries res
// (status, value, instr_count), exactly one result word per input word.
// One word is worked on at a time; after acceptance each word is decoded:
//   loads, halted, nop, bias, imm, faults found at decode: finish at decode
//   const: pool read, then push; ret, print, dup, add/sub/shifts: stack reads,
//   then execute; rot2, rot3: stack reads, execute, then further writes;
//   mul, div, mod: bit-serial multiply/divide, one bit per cycle over 64 bits.
// Stack reads go through a single registered memory port, one entry a cycle.
// Result words sit in an output register, so the next word is accepted while
// a result waits; a stall on res_ready holds only the word after that one.
// Reset (rst, synchronous) empties the stack, clears window base, counter and
// halt flag; stack and pool contents stay undefined until written.
// After a trap, return or fault every instruction answers halted until reset.
`default_nettype none
module stack_bytecode_executor #(
  parameter int STACK_DEPTH = 64,
  parameter int POOL_DEPTH  = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire sbe_pkg::in_word_t item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output sbe_pkg::out_word_t     res
);

  sbe_pkg::cmd_t cmd;
  sbe_pkg::sts_t sts;

  sbe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .sts        (sts),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  sbe_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .POOL_DEPTH  (POOL_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .res_ready (res_ready),
    .sts       (sts),
    .res       (res),
    .res_valid (res_valid)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.lvl == sbe_pkg::LV_INC) |-> !sts.full)
    else $error("push onto full stack");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.lvl == sbe_pkg::LV_DEC) |-> sts.ge1)
    else $error("pop from empty stack");
  a_md_not_instant: assert property (@(posedge clk) disable iff (rst)
    cmd.md_start |=> !cmd.fin)
    else $error("multiply/divide finished too early");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int DEPTH     = 64;
  localparam int N_RANDOM  = 1850;
  localparam int N_DIR     = 25;
  localparam int LIMIT     = 1500000;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_LEN  = 400;
  localparam int PAUSE_AT  = 1000;

  typedef struct packed {
    logic             ld;
    logic [7:0]       opc;
    logic [7:0]       prm;
    logic [7:0]       idx;
    logic [63:0]      val;
    logic             typed;
    sbe_pkg::status_t st;
    logic [63:0]      v;
    logic [15:0]      c;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  sbe_pkg::in_word_t  item = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  sbe_pkg::out_word_t res;

  stack_bytecode_executor u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ld opc prm idx val typed status value count
  row_t dir_rows [N_DIR] = '{
    '{1'b1, 8'h5a, 8'h80, 8'd0, 64'h8000000000000000, 1'b1, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b1, 8'hff, 8'h7f, 8'd255, 64'h7fffffffffffffff, 1'b1, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b1, 8'h00, 8'h00, 8'd1, 64'hffffffffffffffff, 1'b1, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_NOP, 8'h00, 8'hff, 64'hffffffffffffffff, 1'b1, sbe_pkg::ST_OK,
      64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_IMM, 8'h7f, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_IMM, 8'h80, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_ADD, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_PRINT, 8'h00, 8'h00, 64'd0, 1'b1, sbe_pkg::ST_PRINT,
      64'hffffffffffffffff, 16'd4},
    // minimum over -1, quotient then remainder
    '{1'b0, sbe_pkg::OP_CONST, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_IMM, 8'hff, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_DUP, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_PRINT, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_DIV, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_DUP, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_IMM, 8'hff, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_MOD, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_PRINT, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_BIAS, 8'h7f, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_BIAS, 8'h7f, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_CONST, 8'h01, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_BIAS, 8'h80, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_BIAS, 8'h82, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_IMM, 8'h03, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_ROT3, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0},
    '{1'b0, sbe_pkg::OP_ROT2, 8'h00, 8'h00, 64'd0, 1'b0, sbe_pkg::ST_OK, 64'd0, 16'd0}
  };

  // predicted machine state
  logic [63:0] stk [DEPTH];
  int          lvl;
  logic [15:0] wbase;
  logic [63:0] pool [256];
  bit          written [256];
  logic [15:0] icount;
  bit          stopped;

  sbe_pkg::in_word_t  words[$];
  sbe_pkg::out_word_t results_due[$];

  int  sent, rcvd, cycles, nfail, nmis;
  int  send_idle, recv_idle;
  int  hold_left;
  bit  hold_req;
  bit  took;

  function automatic logic [63:0] sdivide(logic [63:0] a, logic [63:0] b, bit rem);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    if (rem) begin
      q = ma % mb;
      return a[63] ? -q : q;
    end
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic bit known_op(logic [7:0] o);
    return o inside {sbe_pkg::OP_TRAP, sbe_pkg::OP_RET, sbe_pkg::OP_BRK, sbe_pkg::OP_PRINT,
                     sbe_pkg::OP_NOP, sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL,
                     sbe_pkg::OP_DIV, sbe_pkg::OP_MOD, sbe_pkg::OP_SHL, sbe_pkg::OP_SHRL,
                     sbe_pkg::OP_SHRA, sbe_pkg::OP_IMM, sbe_pkg::OP_CONST,
                     sbe_pkg::OP_BIAS, sbe_pkg::OP_DUP, sbe_pkg::OP_ROT2, sbe_pkg::OP_ROT3};
  endfunction

  task automatic execute(input sbe_pkg::in_word_t w, output sbe_pkg::out_word_t r);
    logic [63:0] a, b, v, t, sp;
    logic [3:0]  st;
    int          n, idx;
    logic [5:0]  s;
    v  = '0;
    st = sbe_pkg::ST_OK;
    r.instr_count = icount;
    if (w.op) begin
      pool[w.pool_index] = w.pool_value;
      written[w.pool_index] = 1'b1;
    end else if (stopped) begin
      st = sbe_pkg::ST_HALTED;
    end else begin
      n  = lvl;
      sp = {{56{w.param[7]}}, w.param};
      case (w.opcode)
        sbe_pkg::OP_TRAP: st = sbe_pkg::ST_TRAP;
        sbe_pkg::OP_RET: begin
          if (n < 1) st = sbe_pkg::ST_UNDER;
          else begin
            v = stk[n-1];
            st = sbe_pkg::ST_RET;
          end
        end
        sbe_pkg::OP_PRINT: begin
          if (n < 1) st = sbe_pkg::ST_UNDER;
          else begin
            v = stk[n-1];
            lvl = n - 1;
            st = sbe_pkg::ST_PRINT;
          end
        end
        sbe_pkg::OP_NOP: st = sbe_pkg::ST_OK;
        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
        sbe_pkg::OP_MOD, sbe_pkg::OP_SHL, sbe_pkg::OP_SHRL, sbe_pkg::OP_SHRA: begin
          if (n < 2) st = sbe_pkg::ST_UNDER;
          else begin
            b = stk[n-1];
            a = stk[n-2];
            s = b[5:0];
            if ((w.opcode == sbe_pkg::OP_DIV || w.opcode == sbe_pkg::OP_MOD) && b == 0)
              st = sbe_pkg::ST_DIV0;
            else begin
              case (w.opcode)
                sbe_pkg::OP_ADD:  t = a + b;
                sbe_pkg::OP_SUB:  t = a - b;
                sbe_pkg::OP_MUL:  t = a * b;
                sbe_pkg::OP_DIV:  t = sdivide(a, b, 1'b0);
                sbe_pkg::OP_MOD:  t = sdivide(a, b, 1'b1);
                sbe_pkg::OP_SHL:  t = a << s;
                sbe_pkg::OP_SHRL: t = a >> s;
                default:          t = $signed(a) >>> s;
              endcase
              stk[n-2] = t;
              lvl = n - 1;
            end
          end
        end
        sbe_pkg::OP_IMM: begin
          if (n >= DEPTH) st = sbe_pkg::ST_OVER;
          else begin
            stk[n] = sp;
            lvl = n + 1;
          end
        end
        sbe_pkg::OP_CONST: begin
          idx = int'($signed(wbase)) + int'($signed(w.param));
          if (idx < 0 || idx >= 256) st = sbe_pkg::ST_BADIDX;
          else if (n >= DEPTH) st = sbe_pkg::ST_OVER;
          else begin
            stk[n] = pool[idx];
            lvl = n + 1;
          end
        end
        sbe_pkg::OP_BIAS: wbase = wbase + sp[15:0];
        sbe_pkg::OP_DUP: begin
          if (n < 1) st = sbe_pkg::ST_UNDER;
          else if (n >= DEPTH) st = sbe_pkg::ST_OVER;
          else begin
            stk[n] = stk[n-1];
            lvl = n + 1;
          end
        end
        sbe_pkg::OP_ROT2: begin
          if (n < 2) st = sbe_pkg::ST_UNDER;
          else begin
            t = stk[n-1];
            stk[n-1] = stk[n-2];
            stk[n-2] = t;
          end
        end
        sbe_pkg::OP_ROT3: begin
          if (n < 3) st = sbe_pkg::ST_UNDER;
          else begin
            t = stk[n-1];
            stk[n-1] = stk[n-3];
            stk[n-3] = stk[n-2];
            stk[n-2] = t;
          end
        end
        default: st = sbe_pkg::ST_BADOP;
      endcase
      icount = icount + 16'd1;
      if (st != sbe_pkg::ST_OK && st != sbe_pkg::ST_PRINT) stopped = 1'b1;
    end
    r.status = st;
    r.value  = v;
  endtask

  // queue a word; a typed result overrides the predicted one
  task automatic enqueue(input sbe_pkg::in_word_t w, input bit typed,
                         input sbe_pkg::out_word_t e);
    sbe_pkg::out_word_t p;
    execute(w, p);
    words.push_back(w);
    results_due.push_back(typed ? e : p);
  endtask

  task automatic load(input logic [7:0] idx, input logic [63:0] val);
    sbe_pkg::in_word_t w;
    w.op = 1'b1;
    w.opcode = 8'($urandom_range(255));
    w.param = 8'($urandom_range(255));
    w.pool_index = idx;
    w.pool_value = val;
    enqueue(w, 1'b0, '0);
  endtask

  task automatic instr(input logic [7:0] opc, input logic [7:0] prm);
    sbe_pkg::in_word_t w;
    w.op = 1'b0;
    w.opcode = opc;
    w.param = prm;
    w.pool_index = 8'($urandom_range(255));
    w.pool_value = {$urandom, $urandom};
    enqueue(w, 1'b0, '0);
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '0;
      3: return '1;
      4: return 64'($urandom_range(70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic directed();
    sbe_pkg::in_word_t  w;
    sbe_pkg::out_word_t e;
    int                 i;
    for (i = 0; i < N_DIR; i++) begin
      w = '{op: dir_rows[i].ld, opcode: dir_rows[i].opc, param: dir_rows[i].prm,
            pool_index: dir_rows[i].idx, pool_value: dir_rows[i].val};
      e = '{status: dir_rows[i].st, value: dir_rows[i].v, instr_count: dir_rows[i].c};
      enqueue(w, dir_rows[i].typed, e);
    end
  endtask

  task automatic random_part(input int n);
    int          k, r, pushy, b, t, idx, lo, hi;
    logic [7:0]  opc;
    bit          ok;
    pushy = 50;
    for (k = 0; k < n; k++) begin
      if (k % 150 == 0) pushy = $urandom_range(20, 85);
      r = $urandom_range(99);
      if (r < 12) begin
        load(8'($urandom_range(255)), rand_value());
        continue;
      end
      ok = 1'b0;
      while (!ok) begin
        if ($urandom_range(99) < pushy)
          case ($urandom_range(2))
            0: opc = sbe_pkg::OP_IMM;
            1: opc = sbe_pkg::OP_CONST;
            default: opc = sbe_pkg::OP_DUP;
          endcase
        else
          case ($urandom_range(13))
            0: opc = sbe_pkg::OP_PRINT;
            1: opc = sbe_pkg::OP_NOP;
            2: opc = sbe_pkg::OP_BIAS;
            3: opc = sbe_pkg::OP_ROT2;
            4: opc = sbe_pkg::OP_ROT3;
            5: opc = sbe_pkg::OP_ADD;
            6: opc = sbe_pkg::OP_SUB;
            7: opc = sbe_pkg::OP_MUL;
            8: opc = sbe_pkg::OP_DIV;
            9: opc = sbe_pkg::OP_MOD;
            10: opc = sbe_pkg::OP_SHL;
            11: opc = sbe_pkg::OP_SHRL;
            12: opc = sbe_pkg::OP_SHRA;
            default: opc = sbe_pkg::OP_PRINT;
          endcase
        case (opc)
          sbe_pkg::OP_IMM, sbe_pkg::OP_CONST: ok = lvl < DEPTH;
          sbe_pkg::OP_DUP:                    ok = lvl >= 1 && lvl < DEPTH;
          sbe_pkg::OP_PRINT:                  ok = lvl >= 1;
          sbe_pkg::OP_NOP, sbe_pkg::OP_BIAS:  ok = 1'b1;
          sbe_pkg::OP_ROT3:                   ok = lvl >= 3;
          sbe_pkg::OP_DIV, sbe_pkg::OP_MOD:   ok = lvl >= 2 && stk[lvl-1] != 0;
          default:                            ok = lvl >= 2;
        endcase
      end
      b = int'($signed(wbase));
      if (opc == sbe_pkg::OP_CONST) begin
        lo = (b - 128 < 0) ? 0 : b - 128;
        hi = (b + 127 > 255) ? 255 : b + 127;
        idx = $urandom_range(hi, lo);
        if (!written[idx]) load(8'(idx), rand_value());
        instr(sbe_pkg::OP_CONST, 8'(idx - b));
      end else if (opc == sbe_pkg::OP_BIAS) begin
        t = int'($urandom_range(255)) - b;
        if (t > 127) t = 127;
        if (t < -128) t = -128;
        instr(sbe_pkg::OP_BIAS, 8'(t));
      end else begin
        instr(opc, 8'($urandom_range(255)));
      end
    end
  endtask

  // one fault per run, since the machine stays halted until reset
  task automatic fault_tail();
    int         b, k;
    logic [7:0] o;
    case ($urandom_range(8))
      0: instr(sbe_pkg::OP_TRAP, 8'($urandom_range(255)));
      1: instr(sbe_pkg::OP_BRK, 8'($urandom_range(255)));
      2: begin
        o = 8'($urandom_range(255));
        while (known_op(o)) o = 8'($urandom_range(255));
        instr(o, 8'($urandom_range(255)));
      end
      3: begin
        if (lvl < 1) instr(sbe_pkg::OP_IMM, 8'($urandom_range(255)));
        instr(sbe_pkg::OP_RET, 8'($urandom_range(255)));
      end
      4: begin
        while (lvl > 0) instr(sbe_pkg::OP_PRINT, 8'h00);
        instr(sbe_pkg::OP_ADD, 8'h00);
      end
      5: begin
        while (lvl < DEPTH) instr(sbe_pkg::OP_IMM, 8'($urandom_range(255)));
        instr(sbe_pkg::OP_DUP, 8'h00);
      end
      6: begin
        b = int'($signed(wbase));
        if (b == 128) begin
          instr(sbe_pkg::OP_BIAS, 8'h01);
          b = 129;
        end
        instr(sbe_pkg::OP_CONST, (b < 128) ? 8'(-(b + 1)) : 8'(256 - b));
      end
      7: begin
        while (lvl >= DEPTH - 1) instr(sbe_pkg::OP_PRINT, 8'h00);
        instr(sbe_pkg::OP_IMM, 8'h01);
        instr(sbe_pkg::OP_IMM, 8'h00);
        instr($urandom_range(1) ? sbe_pkg::OP_DIV : sbe_pkg::OP_MOD, 8'h00);
      end
      default: instr(sbe_pkg::OP_RET, 8'h00);
    endcase
    for (k = 0; k < 8; k++) begin
      if (k % 3 == 2) load(8'($urandom_range(255)), rand_value());
      else instr(8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  always @(posedge clk) begin
    sbe_pkg::out_word_t e;
    cycles = cycles + 1;
    took = item_valid && item_ready;
    if (!rst && res_valid && res_ready) begin
      rcvd = rcvd + 1;
      if (results_due.size() == 0) begin
        nfail = nfail + 1;
        if (nmis < 10) $display("unexpected result word %p", res);
        nmis = nmis + 1;
      end else begin
        e = results_due.pop_front();
        if (res.status !== e.status || res.value !== e.value ||
            res.instr_count !== e.instr_count) begin
          nfail = nfail + 1;
          if (nmis < 10)
            $display("word %0d: expected st=%0d val=%h cnt=%0d, got st=%0d val=%h cnt=%0d",
                     rcvd - 1, e.status, e.value, e.instr_count,
                     res.status, res.value, res.instr_count);
          nmis = nmis + 1;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("stack_bytecode_executor: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ready = 1'b0;
    end else begin
      res_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int i;
    sent = 0; rcvd = 0; cycles = 0; nfail = 0; nmis = 0;
    hold_left = 0; hold_req = 1'b0; took = 1'b0;
    send_idle = 23; recv_idle = 59;
    lvl = 0; wbase = '0; icount = '0; stopped = 1'b0;
    for (i = 0; i < 256; i++) written[i] = 1'b0;
    directed();
    random_part(N_RANDOM);
    fault_tail();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (sent < words.size()) begin
      @(negedge clk);
      if (item_valid && took) begin
        sent = sent + 1;
        item_valid = 1'b0;
      end
      if (sent == words.size()) break;
      if (sent < words.size() / 3) begin
        send_idle = 23; recv_idle = 59;
      end else if (sent < 2 * words.size() / 3) begin
        send_idle = 59; recv_idle = 23;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      if (!item_valid) begin
        if (sent == HOLD_AT && !took) hold_req = 1'b1;
        if (sent == PAUSE_AT) begin
          while (rcvd != sent) @(negedge clk);
        end
        if ($urandom_range(99) >= send_idle) begin
          item = words[sent];
          item_valid = 1'b1;
        end
      end
    end
    while (results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (nfail == 0) begin
      $display("stack_bytecode_executor: match");
    end else begin
      $display("stack_bytecode_executor: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/sbe_pkg.sv
rtl/sbe_muldiv.sv
rtl/sbe_dpath.sv
rtl/sbe_ctrl.sv
rtl/stack_bytecode_executor.sv
tb/testbench.sv
